[hdl/scfe_pkg.sv]
package scfe_pkg;

    // Widths of the fields on the ports.
    localparam int IN_W  = 10;
    localparam int OUT_W = 8;
    localparam int CFG_W = 9;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SLICES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b1;

    // Configuration register values after reset.
    localparam logic [CFG_W-1:0] TOTAL_RESET = 9'd256;
    localparam logic [CFG_W-1:0] CAP_RESET   = 9'd4;

    // The residency map is stored as rows of ROW_W flags.
    localparam int ROW_SHIFT = 3;
    localparam int ROW_W     = 1 << ROW_SHIFT;

    // Depth of the queue between the front and the engine (a power of two).
    localparam int QDEPTH = 2;

    // One result as the engine hands it to the output ports.
    typedef struct packed {
        logic             hit;
        logic [OUT_W-1:0] served_index;
        logic             evicted;
        logic [OUT_W-1:0] evicted_index;
    } res_t;

endpackage

[hdl/scfe_ram.sv]
module scfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/scfe_front.sv]
module scfe_front #(
    parameter int MAX_SLICES = 256
) (
    input  logic                              start,
    input  logic                              busy,
    input  logic [scfe_pkg::IN_W-1:0]         slice_index,
    input  logic [scfe_pkg::CFG_W-1:0]        total_slices,
    output logic                              push,
    output logic [$clog2(MAX_SLICES)-1:0]     push_idx
);

    localparam int IW   = $clog2(MAX_SLICES);
    localparam int MW   = $clog2(MAX_SLICES + 1);
    localparam int AW   = (scfe_pkg::IN_W > scfe_pkg::CFG_W) ? scfe_pkg::IN_W : scfe_pkg::CFG_W;
    localparam int CMPW = (AW > MW) ? AW : MW;

    logic [CMPW-1:0] total_x;
    logic [CMPW-1:0] max_x;
    logic [CMPW-1:0] total_eff;
    logic [CMPW-1:0] req_x;
    logic [CMPW-1:0] clamped;

    // A request is taken whenever the queue has room and no clearing runs.
    assign push = start & ~busy;

    // Slices in use: zero counts as one, and the map size is the ceiling.
    always_comb
    begin
        total_x = CMPW'(total_slices);
        max_x   = CMPW'(MAX_SLICES);
        req_x   = CMPW'(slice_index);
        if (total_x == '0)
        begin
            total_eff = CMPW'(1);
        end
        else if (total_x > max_x)
        begin
            total_eff = max_x;
        end
        else
        begin
            total_eff = total_x;
        end
        clamped = (req_x >= total_eff) ? (total_eff - CMPW'(1)) : req_x;
    end

    assign push_idx = IW'(clamped);

endmodule

[hdl/scfe_queue.sv]
module scfe_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             not_empty,
    output logic             full,
    output logic [WIDTH-1:0] head
);

    localparam int PW = $clog2(scfe_pkg::QDEPTH);
    localparam int CW = $clog2(scfe_pkg::QDEPTH + 1);

    logic [WIDTH-1:0] entry_reg [scfe_pkg::QDEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(scfe_pkg::QDEPTH));
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/scfe_back.sv]
module scfe_back #(
    parameter int MAX_SLICES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  logic [$clog2(MAX_SLICES)-1:0]  q_idx,
    output logic                           q_pop,
    input  logic [scfe_pkg::CFG_W-1:0]     capacity,
    output logic                           clearing,
    output logic                           res_valid,
    output scfe_pkg::res_t                 res
);

    localparam int IW    = $clog2(MAX_SLICES);
    localparam int RS    = scfe_pkg::ROW_SHIFT;
    localparam int RW    = scfe_pkg::ROW_W;
    localparam int NR0   = (MAX_SLICES + RW - 1) / RW;
    localparam int NROWS = (NR0 < 2) ? 2 : NR0;
    localparam int RAW   = $clog2(NROWS);
    localparam int XW    = RAW + RS;
    localparam int CNTW  = $clog2(MAX_SLICES + 1);
    localparam int CMPW  = (CNTW > scfe_pkg::CFG_W) ? CNTW : scfe_pkg::CFG_W;
    localparam int OW    = scfe_pkg::OUT_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_EVRD  = 3'd5;
    localparam logic [2:0] S_EVWR  = 3'd6;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [RAW-1:0]  row_ctr_reg;
    logic [RAW-1:0]  row_ctr_next;
    logic [XW-1:0]   cur_reg;
    logic [XW-1:0]   cur_next;
    logic [XW-1:0]   victim_reg;
    logic [XW-1:0]   victim_next;
    logic [XW-1:0]   min_reg;
    logic [XW-1:0]   min_next;
    logic [XW-1:0]   max_reg;
    logic [XW-1:0]   max_next;
    logic            found_reg;
    logic            found_next;
    logic            pend_reg;
    logic            pend_next;
    logic [RAW-1:0]  pend_row_reg;
    logic [RAW-1:0]  pend_row_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            done_reg;
    logic            done_next;
    scfe_pkg::res_t  res_reg;
    scfe_pkg::res_t  res_next;

    logic            ram_we;
    logic [RAW-1:0]  ram_waddr;
    logic [RW-1:0]   ram_wdata;
    logic            ram_re;
    logic [RAW-1:0]  ram_raddr;
    logic [RW-1:0]   ram_rdata;

    logic [XW-1:0]   q_idx_x;
    logic [RS-1:0]   lo_bit;
    logic [RS-1:0]   hi_bit;
    logic [XW-1:0]   dist_lo;
    logic [XW-1:0]   dist_hi;
    logic [XW-1:0]   pick;
    logic [CNTW-1:0] count_inc;

    scfe_ram #(
        .WIDTH (RW),
        .DEPTH (NROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_idx_x   = XW'(q_idx);
    assign count_inc = count_reg + CNTW'(1);
    assign clearing  = (state_reg == S_CLEAR);
    assign res_valid = done_reg;
    assign res       = res_reg;

    // Lowest and highest set flag of the row coming back from the scan.
    always_comb
    begin
        lo_bit = '0;
        hi_bit = '0;
        for (int i = RW - 1; i >= 0; i--)
        begin
            if (ram_rdata[i])
            begin
                lo_bit = RS'(i);
            end
        end
        for (int i = 0; i < RW; i++)
        begin
            if (ram_rdata[i])
            begin
                hi_bit = RS'(i);
            end
        end
    end

    // The furthest resident slice is the lowest or the highest one.
    always_comb
    begin
        dist_lo = cur_reg - min_reg;
        dist_hi = max_reg - cur_reg;
        pick    = (dist_lo >= dist_hi) ? min_reg : max_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        row_ctr_next  = row_ctr_reg;
        cur_next      = cur_reg;
        victim_next   = victim_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        found_next    = found_reg;
        pend_next     = 1'b0;
        pend_row_next = row_ctr_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = row_ctr_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = row_ctr_reg;

        if (pend_reg && (ram_rdata != '0))
        begin
            if (!found_reg)
            begin
                min_next = {pend_row_reg, lo_bit};
            end
            max_next   = {pend_row_reg, hi_bit};
            found_next = 1'b1;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = row_ctr_reg;
                ram_wdata    = '0;
                row_ctr_next = row_ctr_reg + RAW'(1);
                if (row_ctr_reg == RAW'(NROWS - 1))
                begin
                    row_ctr_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_idx_x;
                    ram_re     = 1'b1;
                    ram_raddr  = q_idx_x[XW-1:RS];
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                res_next.served_index  = OW'(cur_reg);
                res_next.evicted       = 1'b0;
                res_next.evicted_index = '0;
                if (ram_rdata[cur_reg[RS-1:0]])
                begin
                    res_next.hit = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    res_next.hit = 1'b0;
                    ram_we       = 1'b1;
                    ram_waddr    = cur_reg[XW-1:RS];
                    ram_wdata    = ram_rdata | (RW'(1) << cur_reg[RS-1:0]);
                    count_next   = count_inc;
                    if (CMPW'(count_inc) > CMPW'(capacity))
                    begin
                        found_next   = 1'b0;
                        row_ctr_next = '0;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN:
            begin
                ram_re        = 1'b1;
                ram_raddr     = row_ctr_reg;
                pend_next     = 1'b1;
                pend_row_next = row_ctr_reg;
                row_ctr_next  = row_ctr_reg + RAW'(1);
                if (row_ctr_reg == RAW'(NROWS - 1))
                begin
                    row_ctr_next = '0;
                    state_next   = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EVRD;
            end
            S_EVRD:
            begin
                victim_next = pick;
                ram_re      = 1'b1;
                ram_raddr   = pick[XW-1:RS];
                state_next  = S_EVWR;
            end
            S_EVWR:
            begin
                ram_we                 = 1'b1;
                ram_waddr              = victim_reg[XW-1:RS];
                ram_wdata              = ram_rdata & ~(RW'(1) << victim_reg[RS-1:0]);
                count_next             = count_reg - CNTW'(1);
                res_next.evicted       = 1'b1;
                res_next.evicted_index = OW'(victim_reg);
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            row_ctr_reg <= '0;
            found_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_ctr_reg <= row_ctr_next;
            found_reg   <= found_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        victim_reg   <= victim_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        pend_row_reg <= pend_row_next;
        res_reg      <= res_next;
    end

endmodule

[hdl/slice_cache_furthest_eviction_core.sv]
// Residency manager for a cache of numbered slices with furthest-slice
// eviction. A request is transferred at a rising edge where start is high and
// busy is low; its result appears on the result ports for exactly one cycle,
// marked by done, and the receiver cannot stall it. Requests go into a
// two-entry queue, so up to two may be pending while the engine works. When
// the engine is free, a hit or a miss that needs no eviction is popped from
// the queue in the idle state and decided in the look state, which registers
// done. A miss that pushes the resident count above the capacity goes on to
// an eviction: the engine walks the residency memory one 8-flag row per cycle
// through its single read port to find the lowest and highest resident
// slice, then clears the victim. After reset the engine clears the residency
// memory, one row per cycle; busy stays high during that pass, while
// configuration writes are accepted as always.
module slice_cache_furthest_eviction_core #(
    parameter int MAX_SLICES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [scfe_pkg::IN_W-1:0]           slice_index,
    output logic                                done,
    output logic                                hit,
    output logic [scfe_pkg::OUT_W-1:0]          served_index,
    output logic                                evicted,
    output logic [scfe_pkg::OUT_W-1:0]          evicted_index,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scfe_pkg::CFG_W-1:0]          cfg_data
);

    localparam int IW = $clog2(MAX_SLICES);

    logic [scfe_pkg::CFG_W-1:0] total_slices_reg;
    logic [scfe_pkg::CFG_W-1:0] capacity_reg;

    logic          push;
    logic [IW-1:0] push_idx;
    logic          q_valid;
    logic          q_full;
    logic [IW-1:0] q_idx;
    logic          q_pop;
    logic          clearing;
    logic          res_valid;
    scfe_pkg::res_t res;

    // The configuration registers take every transfer; only configured
    // indexes change anything.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_slices_reg <= scfe_pkg::TOTAL_RESET;
            capacity_reg     <= scfe_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                scfe_pkg::CFG_TOTAL_SLICES:
                begin
                    total_slices_reg <= cfg_data;
                end
                scfe_pkg::CFG_CAPACITY:
                begin
                    capacity_reg <= cfg_data;
                end
                default:
                begin
                    total_slices_reg <= total_slices_reg;
                end
            endcase
        end
    end

    // New requests are held off while the queue is full or while the
    // residency memory is still being cleared after reset.
    assign busy = q_full | clearing;

    // The front clamps the requested index to the slices in use.
    scfe_front #(
        .MAX_SLICES (MAX_SLICES)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .slice_index  (slice_index),
        .total_slices (total_slices_reg),
        .push         (push),
        .push_idx     (push_idx)
    );

    scfe_queue #(
        .WIDTH (IW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_idx),
        .pop       (q_pop),
        .not_empty (q_valid),
        .full      (q_full),
        .head      (q_idx)
    );

    // The engine owns the residency memory and the resident count.
    scfe_back #(
        .MAX_SLICES (MAX_SLICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_idx     (q_idx),
        .q_pop     (q_pop),
        .capacity  (capacity_reg),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res       (res)
    );

    assign done          = res_valid;
    assign hit           = res.hit;
    assign served_index  = res.served_index;
    assign evicted       = res.evicted;
    assign evicted_index = res.evicted_index;

endmodule

[hdl/scfe_checker.sv]
module scfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       done,
    input logic       hit,
    input logic       evicted,
    input logic [7:0] evicted_index
);

    // A hit never evicts anything.
    assert property (@(posedge clk) disable iff (!rst_n) (done && hit) |-> !evicted)
        else $error("hit result reports an eviction");

    // Without an eviction the evicted index reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (evicted_index == 8'd0))
        else $error("evicted index is not zero without an eviction");

    // Each request passes through the idle state and then the look state before
    // its result, so results never come in adjacent cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("results in two adjacent cycles");

endmodule

bind slice_cache_furthest_eviction_core scfe_checker u_scfe_checker (.*);
